// File: src/sound_level_trigger_macros.svh
// ----------------------------------------------------------------------------
// Sound level trigger assertion macros
// Shared clocked assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SOUND_LEVEL_TRIGGER_MACROS_SVH
`define SOUND_LEVEL_TRIGGER_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define SLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after the trigger condition.
`define SLT_ASSERT_HOLD(label, trig, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> $stable(sig)) \
        else $error(msg);

`endif

// File: src/slt_pkg.sv
// ----------------------------------------------------------------------------
// Sound level trigger package
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package slt_pkg;

    // Default geometry.
    localparam int WINDOW_DEFAULT      = 10;
    localparam int SAMPLE_BITS_DEFAULT = 10;

    // Sensitivity register.
    localparam int              SENS_BITS  = 7;
    localparam logic [SENS_BITS-1:0] SENS_RESET = 7'd50;

    // Percent scale used by the threshold test.
    localparam int              PCT_BITS = 7;
    localparam logic [PCT_BITS-1:0] PERCENT = 7'd100;

    // Item modes.
    localparam logic [1:0] MODE_SAMPLE      = 2'd0;
    localparam logic [1:0] MODE_READ_COLOR  = 2'd1;
    localparam logic [1:0] MODE_READ_METEOR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_DIV,
        S_AVG,
        S_MUL,
        S_CMP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
        logic div_step;
        logic avg_load;
        logic mul;
        logic cmp;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sample_go;
        logic wrap;
        logic out_free;
    } status_t;

endpackage

// File: src/slt_datapath.sv
// ----------------------------------------------------------------------------
// Sound level trigger datapath
// Window accumulator, reciprocal divider, threshold products, flags and output.
// ----------------------------------------------------------------------------
module slt_datapath #(
    parameter int WINDOW      = slt_pkg::WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = slt_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [slt_pkg::SENS_BITS-1:0] cfg_wdata,
    input  logic [1:0]                    mode,
    input  logic                          active,
    input  logic [SAMPLE_BITS-1:0]        sample,
    input  logic                          out_ready,
    input  slt_pkg::cmd_t                 cmd,
    output slt_pkg::status_t              status,
    output logic                          out_valid,
    output logic                          flag,
    output logic [SAMPLE_BITS-1:0]        average_level,
    output logic                          average_ready
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int REC_SH = SUM_W + $clog2(WINDOW);
    localparam int REC_W  = SUM_W + 1;
    localparam int PROD_W = REC_SH + SAMPLE_BITS;
    localparam int PA_W   = SAMPLE_BITS + slt_pkg::PCT_BITS;
    localparam int PB_W   = SAMPLE_BITS + slt_pkg::SENS_BITS + 1;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW - 1);
    // Rounded-up reciprocal of WINDOW. With REC_SH fraction bits the product
    // gives the exact rounded-down quotient for every possible window sum.
    localparam logic [REC_W-1:0]  RECIP     = REC_W'(((1 << REC_SH) + WINDOW - 1) / WINDOW);

    // Captured item.
    logic [1:0]             mode_reg;
    logic                   active_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    // Block state.
    logic [slt_pkg::SENS_BITS-1:0] sens_reg;
    logic [IDX_W-1:0]       idx_reg,    idx_next;
    logic [SUM_W-1:0]       acc_reg,    acc_next;
    logic [SAMPLE_BITS-1:0] avg_reg,    avg_next;
    logic                   valid_reg,  valid_next;
    logic                   color_reg,  color_next;
    logic                   meteor_reg, meteor_next;
    logic                   flag_reg,   flag_next;

    // Divider: holds the window sum, then the quotient.
    logic [SUM_W-1:0]       quo_reg,    quo_next;

    // Threshold products.
    logic                   above_reg;
    logic [PA_W-1:0]        pa_reg;
    logic [PB_W-1:0]        pb_reg;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic                   out_flag_reg;
    logic [SAMPLE_BITS-1:0] out_avg_reg;
    logic                   out_rdy_reg;

    logic                   wrap;
    logic [SUM_W-1:0]       sum_in;
    logic [PROD_W-1:0]      prod;
    logic [slt_pkg::SENS_BITS:0] sens_plus;

    assign wrap      = (idx_reg == LAST_IDX);
    assign sum_in    = acc_reg + SUM_W'(sample_reg);
    assign prod      = PROD_W'(quo_reg) * PROD_W'(RECIP);
    assign sens_plus = {1'b0, sens_reg} + (slt_pkg::SENS_BITS + 1)'(1);

    assign status.sample_go = (mode_reg == slt_pkg::MODE_SAMPLE) && active_reg;
    assign status.wrap      = wrap;
    assign status.out_free  = ~out_valid_reg | out_ready;

    always_comb
    begin
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        avg_next       = avg_reg;
        valid_next     = valid_reg;
        color_next     = color_reg;
        meteor_next    = meteor_reg;
        flag_next      = flag_reg;
        quo_next       = quo_reg;
        out_valid_next = out_valid_reg;

        if (cmd.apply)
        begin
            flag_next = 1'b0;
            case (mode_reg)
                slt_pkg::MODE_SAMPLE:
                begin
                    if (active_reg)
                    begin
                        if (wrap)
                        begin
                            // The accumulator and the current sample hold every window entry
                            // once, so the full window sum goes straight to the divider.
                            idx_next = '0;
                            acc_next = '0;
                            quo_next = sum_in;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                            acc_next = sum_in;
                        end
                    end
                    else
                    begin
                        valid_next = 1'b0;
                    end
                end
                slt_pkg::MODE_READ_COLOR:
                begin
                    flag_next  = color_reg;
                    color_next = 1'b0;
                end
                slt_pkg::MODE_READ_METEOR:
                begin
                    flag_next   = meteor_reg;
                    meteor_next = 1'b0;
                end
                default:
                begin
                    flag_next = 1'b0;
                end
            endcase
        end

        if (cmd.div_step)
        begin
            quo_next = SUM_W'(prod[PROD_W-1:REC_SH]);
        end

        if (cmd.avg_load)
        begin
            avg_next   = quo_reg[SAMPLE_BITS-1:0];
            valid_next = 1'b1;
        end

        // floor(rise * 100 / avg) > sens is the same as rise * 100 >= (sens + 1) * avg.
        // A zero average makes the right side zero, so any rise fires.
        if (cmd.cmp && above_reg && ({1'b0, pa_reg} >= pb_reg))
        begin
            color_next  = 1'b1;
            meteor_next = 1'b1;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_reg      <= slt_pkg::SENS_RESET;
            idx_reg       <= '0;
            acc_reg       <= '0;
            avg_reg       <= '0;
            valid_reg     <= 1'b0;
            color_reg     <= 1'b0;
            meteor_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sens_reg <= cfg_wdata;
            end
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            avg_reg       <= avg_next;
            valid_reg     <= valid_next;
            color_reg     <= color_next;
            meteor_reg    <= meteor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            active_reg <= active;
            sample_reg <= sample;
        end
        if (cmd.mul)
        begin
            above_reg <= valid_reg && (sample_reg > avg_reg);
            pa_reg    <= PA_W'(sample_reg - avg_reg) * PA_W'(slt_pkg::PERCENT);
            pb_reg    <= PB_W'(sens_plus) * PB_W'(avg_reg);
        end
        if (cmd.out_load)
        begin
            out_flag_reg <= flag_reg;
            out_avg_reg  <= avg_reg;
            out_rdy_reg  <= valid_reg;
        end
        flag_reg <= flag_next;
        quo_reg  <= quo_next;
    end

    assign out_valid     = out_valid_reg;
    assign flag          = out_flag_reg;
    assign average_level = out_avg_reg;
    assign average_ready = out_rdy_reg;

endmodule

// File: src/slt_ctrl.sv
// ----------------------------------------------------------------------------
// Sound level trigger controller
// Sequences one item: apply, for samples divide (on wrap), multiply and compare, output.
// ----------------------------------------------------------------------------
module slt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  slt_pkg::status_t status,
    output slt_pkg::cmd_t    cmd
);

    slt_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = slt_pkg::S_APPLY;
                end
            end
            slt_pkg::S_APPLY:
            begin
                if (!status.sample_go)
                begin
                    state_next = slt_pkg::S_DONE;
                end
                else if (status.wrap)
                begin
                    state_next = slt_pkg::S_DIV;
                end
                else
                begin
                    state_next = slt_pkg::S_MUL;
                end
            end
            slt_pkg::S_DIV:  state_next = slt_pkg::S_AVG;
            slt_pkg::S_AVG:  state_next = slt_pkg::S_MUL;
            slt_pkg::S_MUL:  state_next = slt_pkg::S_CMP;
            slt_pkg::S_CMP:  state_next = slt_pkg::S_DONE;
            slt_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = slt_pkg::S_IDLE;
                end
            end
            default:         state_next = slt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            slt_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            slt_pkg::S_APPLY: cmd.apply    = 1'b1;
            slt_pkg::S_DIV:   cmd.div_step = 1'b1;
            slt_pkg::S_AVG:   cmd.avg_load = 1'b1;
            slt_pkg::S_MUL:   cmd.mul      = 1'b1;
            slt_pkg::S_CMP:   cmd.cmp      = 1'b1;
            slt_pkg::S_DONE:  cmd.out_load = status.out_free;
            default:          cmd          = '0;
        endcase
    end

endmodule

// File: src/sound_level_trigger.sv
// ----------------------------------------------------------------------------
// Sound level trigger
// Block-average percent-threshold detector with two sticky trigger flags.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready (mode, active, sample) and every item
// yields exactly one result beat on out_valid/out_ready (flag, average_level,
// average_ready). The sensitivity register is written with cfg_we/cfg_wdata in
// any cycle; write it only while no item is in flight.
// A sample item with active high adds the sample to the running window sum.
// When the window fills, the sum is divided by WINDOW with one multiply by a
// rounded-up reciprocal.
// A read item, an inactive sample or an unused mode passes through the apply
// and done states; a sample that does not close the window also goes through
// multiply and compare, and the sample that closes it adds divide and average
// before them, which sets the worst case. The next item is accepted in the cycle
// after the result is loaded into the output register.
// Items are handled one at a time. The output register lets the next item be
// accepted while a result still waits; if the receiver stalls longer, the
// block holds the following result and stops accepting until the beat goes.
// Reset clears the window position, sum, average, validity and both flags,
// and sets the sensitivity to 50. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sound_level_trigger #(
    parameter int WINDOW      = slt_pkg::WINDOW_DEFAULT,
    parameter int SAMPLE_BITS = slt_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [slt_pkg::SENS_BITS-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic                          active,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          flag,
    output logic [SAMPLE_BITS-1:0]        average_level,
    output logic                          average_ready
);

    // Command and status between the sequencer and the datapath.
    slt_pkg::cmd_t    cmd;
    slt_pkg::status_t status;

    slt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slt_datapath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mode          (mode),
        .active        (active),
        .sample        (sample),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .flag          (flag),
        .average_level (average_level),
        .average_ready (average_ready)
    );

endmodule

// File: src/slt_checker.sv
// ----------------------------------------------------------------------------
// Sound level trigger port checker
// Port-level properties of the result channel and the item sequencing.
// ----------------------------------------------------------------------------
`include "sound_level_trigger_macros.svh"

module slt_checker #(
    parameter int SAMPLE_BITS = slt_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [SAMPLE_BITS-1:0]        average_level
);

    // A stalled result beat stays offered.
    `SLT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped")

    // A stalled result beat keeps its average.
    `SLT_ASSERT_HOLD(a_out_stable, out_valid && !out_ready, average_level, "result changed")

    // Items are handled one at a time, so the block is busy right after a beat.
    `SLT_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "accepted two beats in a row")

    // No result can appear in the cycle right after an item is taken.
    `SLT_ASSERT(a_no_early, in_valid && in_ready && !out_valid |=> !out_valid, "early result")

endmodule

bind sound_level_trigger slt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_slt_checker (.*);
